// ===== rtl/stepper_position_homing_controller_top_defines.svh =====
// Assertion macros used by the stepper homing controller core.
`ifndef STEPPER_POSITION_HOMING_CONTROLLER_TOP_DEFINES_SVH
`define STEPPER_POSITION_HOMING_CONTROLLER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spc_pkg.sv =====
// Types, codes and constants of the stepper position and homing controller.
`default_nettype none

package spc_pkg;

    localparam int STEP_BITS_DEF = 16;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int PCT_W      = 7;
    localparam int CMD_W      = 2;
    localparam int STATE_W    = 2;
    localparam int POS_OUT_W  = 16;
    localparam int GOAL_W     = 17;
    localparam int CNT_W      = 17;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TARGET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HOME   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd3;

    localparam logic [STATE_W-1:0] ST_IDLE    = 2'd0;
    localparam logic [STATE_W-1:0] ST_OPENING = 2'd1;
    localparam logic [STATE_W-1:0] ST_CLOSING = 2'd2;
    localparam logic [STATE_W-1:0] ST_ERROR   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERTRAVEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_TRAVEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOMING_TRAVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERCENT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_ENDSTOP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DIR       = 3'd6;

    localparam logic [CFG_W-1:0] STEP_DELAY_RST    = 16'd10;
    localparam logic [CFG_W-1:0] OVERTRAVEL_RST    = 16'd0;
    localparam logic [CFG_W-1:0] FULL_TRAVEL_RST   = 16'd1000;
    localparam logic [CFG_W-1:0] HOMING_TRAVEL_RST = 16'd1100;
    localparam logic [PCT_W-1:0] MIN_PERCENT_RST   = 7'd0;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // Division by 100 is a multiply by ceil(2^30 / 100) and a shift; it is
    // exact for every product of a 16-bit travel and a percent up to 100.
    localparam int RECIP_100   = 10737419;
    localparam int SCALE_SHIFT = 30;
    localparam int SCALE_W     = 31;
    localparam int PROD_W      = CFG_W + SCALE_W;

    typedef logic [SCALE_W-1:0] pct_scale_t [0:100];

    function automatic pct_scale_t build_pct_scale();
        pct_scale_t t;
        for (int i = 0; i <= 100; i++)
        begin
            t[i] = SCALE_W'(i * RECIP_100);
        end
        return t;
    endfunction

    localparam pct_scale_t PCT_SCALE = build_pct_scale();

    typedef struct packed {
        logic [CFG_W-1:0] step_delay_ticks;
        logic [CFG_W-1:0] overtravel_steps;
        logic [CFG_W-1:0] full_travel_steps;
        logic [CFG_W-1:0] homing_travel_steps;
        logic [PCT_W-1:0] min_percent;
        logic             invert_endstop;
        logic             invert_dir;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [PCT_W-1:0] target_percent;
        logic             endstop_level;
    } item_t;

    typedef struct packed {
        logic                 step_pulse;
        logic                 dir_level;
        logic                 enable_level;
        logic [STATE_W-1:0]   motion_state;
        logic                 position_valid;
        logic [POS_OUT_W-1:0] position;
        logic                 homing_active;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/spc_regs.sv =====
// Configuration register file of the stepper homing controller.
`default_nettype none

module spc_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [spc_pkg::CFG_W-1:0]     cfg_data,
    output spc_pkg::cfg_t                      cfg
);
    import spc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_delay_ticks    <= STEP_DELAY_RST;
            cfg_reg.overtravel_steps    <= OVERTRAVEL_RST;
            cfg_reg.full_travel_steps   <= FULL_TRAVEL_RST;
            cfg_reg.homing_travel_steps <= HOMING_TRAVEL_RST;
            cfg_reg.min_percent         <= MIN_PERCENT_RST;
            cfg_reg.invert_endstop      <= 1'b0;
            cfg_reg.invert_dir          <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_DELAY:    cfg_reg.step_delay_ticks    <= cfg_data;
                REG_OVERTRAVEL:    cfg_reg.overtravel_steps    <= cfg_data;
                REG_FULL_TRAVEL:   cfg_reg.full_travel_steps   <= cfg_data;
                REG_HOMING_TRAVEL: cfg_reg.homing_travel_steps <= cfg_data;
                REG_MIN_PERCENT:   cfg_reg.min_percent         <= cfg_data[PCT_W-1:0];
                REG_INV_ENDSTOP:   cfg_reg.invert_endstop      <= cfg_data[0];
                REG_INV_DIR:       cfg_reg.invert_dir          <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/spc_core.sv =====
// Axis state and the combinational update of that state for one request.
`default_nettype none
`include "stepper_position_homing_controller_top_defines.svh"

module spc_core #(
    parameter int STEP_BITS = spc_pkg::STEP_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire spc_pkg::cfg_t cfg,
    input  wire logic          fire,
    input  wire spc_pkg::item_t item,
    output spc_pkg::res_t      res
);
    import spc_pkg::*;

    localparam int CMP_W = ((STEP_BITS > GOAL_W) ? STEP_BITS : GOAL_W) + 1;

    logic                     homing_reg, homing_next;
    logic                     known_reg, known_next;
    logic [STEP_BITS-1:0]     pos_reg, pos_next;
    logic signed [GOAL_W-1:0] goal_reg, goal_next;
    logic [STATE_W-1:0]       state_reg, state_next;
    logic [CNT_W-1:0]         hdiv_reg, hdiv_next;
    logic [CNT_W-1:0]         mdiv_reg, mdiv_next;
    logic [CNT_W-1:0]         hoc_reg, hoc_next;
    logic [CNT_W-1:0]         moc_reg, moc_next;
    logic                     dir_reg, dir_next;
    logic                     en_reg, en_next;
    logic                     pulse;

    logic                     at_end;
    logic                     dir_fwd;
    logic                     dir_back;
    logic [PCT_W-1:0]         pct_clamp;
    logic [PCT_W-1:0]         pct_eff;
    logic [PROD_W-1:0]        goal_prod;
    logic signed [GOAL_W-1:0] goal_calc;
    logic signed [CMP_W-1:0]  pos_x;
    logic signed [CMP_W-1:0]  goal_x;
    logic signed [CMP_W-1:0]  ovr_x;
    logic [CMP_W-1:0]         pos_next_ext;
    logic [CNT_W-1:0]         delay_x;
    logic [CNT_W-1:0]         ovr_cnt;

    assign at_end   = item.endstop_level ^ cfg.invert_endstop;
    assign dir_fwd  = cfg.invert_dir;
    assign dir_back = ~cfg.invert_dir;

    assign pct_clamp = (item.target_percent > PCT_MAX) ? PCT_MAX : item.target_percent;
    assign pct_eff   = (pct_clamp < cfg.min_percent) ? '0 : pct_clamp;
    assign goal_prod = PROD_W'(cfg.full_travel_steps) * PROD_W'(PCT_SCALE[pct_eff]);
    assign goal_calc = $signed(goal_prod[SCALE_SHIFT +: GOAL_W]);

    assign pos_x   = $signed(CMP_W'(pos_reg));
    assign goal_x  = CMP_W'(goal_reg);
    assign ovr_x   = $signed(CMP_W'(cfg.overtravel_steps));
    assign delay_x = CNT_W'(cfg.step_delay_ticks);
    assign ovr_cnt = CNT_W'(cfg.overtravel_steps);

    always_comb
    begin
        homing_next = homing_reg;
        known_next  = known_reg;
        pos_next    = pos_reg;
        goal_next   = goal_reg;
        state_next  = state_reg;
        hdiv_next   = hdiv_reg;
        mdiv_next   = mdiv_reg;
        hoc_next    = hoc_reg;
        moc_next    = moc_reg;
        dir_next    = dir_reg;
        en_next     = en_reg;
        pulse       = 1'b0;

        case (item.command)
            CMD_TICK:
            begin
                if (homing_reg)
                begin
                    en_next   = 1'b0;
                    hdiv_next = hdiv_reg + 1'b1;
                    if (hdiv_reg > delay_x)
                    begin
                        hdiv_next = '0;
                        if (goal_reg < 0 && !at_end)
                        begin
                            goal_next = goal_reg + GOAL_W'(1);
                            dir_next  = dir_back;
                            pulse     = 1'b1;
                        end
                        else if (at_end)
                        begin
                            if (hoc_reg > ovr_cnt)
                            begin
                                hoc_next    = '0;
                                state_next  = ST_IDLE;
                                known_next  = 1'b1;
                                pos_next    = '0;
                                goal_next   = '0;
                                homing_next = 1'b0;
                            end
                            else
                            begin
                                hoc_next = hoc_reg + 1'b1;
                                dir_next = dir_back;
                                pulse    = 1'b1;
                            end
                        end
                        else
                        begin
                            state_next  = ST_ERROR;
                            known_next  = 1'b0;
                            pos_next    = '0;
                            goal_next   = '0;
                            homing_next = 1'b0;
                        end
                    end
                end
                else if (known_reg)
                begin
                    mdiv_next = mdiv_reg + 1'b1;
                    if (mdiv_reg > delay_x)
                    begin
                        mdiv_next = '0;
                        if (pos_x < goal_x)
                        begin
                            en_next    = 1'b0;
                            dir_next   = dir_fwd;
                            pulse      = 1'b1;
                            pos_next   = pos_reg + 1'b1;
                            state_next = ST_OPENING;
                        end
                        else if (pos_x > goal_x && !at_end)
                        begin
                            en_next    = 1'b0;
                            dir_next   = dir_back;
                            pulse      = 1'b1;
                            pos_next   = pos_reg - 1'b1;
                            state_next = ST_CLOSING;
                        end
                        else if (at_end && state_reg == ST_CLOSING)
                        begin
                            if (moc_reg > ovr_cnt)
                            begin
                                moc_next   = '0;
                                pos_next   = '0;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                moc_next = moc_reg + 1'b1;
                                en_next  = 1'b0;
                                dir_next = dir_back;
                                pulse    = 1'b1;
                            end
                        end
                        else
                        begin
                            if (state_reg != ST_ERROR)
                            begin
                                state_next = ST_IDLE;
                            end
                            en_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    en_next = 1'b1;
                end
            end
            CMD_TARGET:
            begin
                if (known_reg && state_reg != ST_ERROR)
                begin
                    goal_next = goal_calc;
                end
            end
            CMD_HOME:
            begin
                if (!homing_reg)
                begin
                    if (!at_end)
                    begin
                        homing_next = 1'b1;
                        known_next  = 1'b0;
                        pos_next    = '0;
                        state_next  = ST_CLOSING;
                        goal_next   = -$signed({1'b0, cfg.homing_travel_steps});
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        known_next = 1'b1;
                        pos_next   = '0;
                        goal_next  = '0;
                    end
                end
            end
            default:
            begin
                if (!homing_reg && state_reg == ST_IDLE)
                begin
                    if (at_end)
                    begin
                        if (known_reg)
                        begin
                            if (pos_x > ovr_x)
                            begin
                                state_next = ST_ERROR;
                                known_next = 1'b0;
                                pos_next   = '0;
                            end
                        end
                        else
                        begin
                            known_next = 1'b1;
                            pos_next   = '0;
                            state_next = ST_IDLE;
                        end
                    end
                    else if (known_reg && pos_reg == '0)
                    begin
                        state_next = ST_ERROR;
                        known_next = 1'b0;
                        pos_next   = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            homing_reg <= 1'b0;
            known_reg  <= 1'b0;
            pos_reg    <= '0;
            goal_reg   <= '0;
            state_reg  <= ST_IDLE;
            hdiv_reg   <= '0;
            mdiv_reg   <= '0;
            hoc_reg    <= '0;
            moc_reg    <= '0;
            dir_reg    <= 1'b0;
            en_reg     <= 1'b1;
        end
        else if (fire)
        begin
            homing_reg <= homing_next;
            known_reg  <= known_next;
            pos_reg    <= pos_next;
            goal_reg   <= goal_next;
            state_reg  <= state_next;
            hdiv_reg   <= hdiv_next;
            mdiv_reg   <= mdiv_next;
            hoc_reg    <= hoc_next;
            moc_reg    <= moc_next;
            dir_reg    <= dir_next;
            en_reg     <= en_next;
        end
    end

    assign pos_next_ext = CMP_W'(pos_next);

    always_comb
    begin
        res.step_pulse     = pulse;
        res.dir_level      = dir_next;
        res.enable_level   = en_next;
        res.motion_state   = state_next;
        res.position_valid = known_next;
        res.position       = known_next ? pos_next_ext[POS_OUT_W-1:0] : '0;
        res.homing_active  = homing_next;
    end

    `SPC_ASSERT_SAME(a_homing_unknown, homing_reg, !known_reg,
        "position is marked known during a homing run")
    `SPC_ASSERT_SAME(a_homing_closing, homing_reg, state_reg == ST_CLOSING,
        "homing run is not in the closing state")
    `SPC_ASSERT_SAME(a_unknown_zero, !known_reg, pos_reg == '0,
        "unknown position holds a nonzero step count")
    `SPC_ASSERT_SAME(a_pulse_on_tick, pulse, item.command == CMD_TICK,
        "step pulse issued by a request that is not a tick")
    `SPC_ASSERT_NEXT(a_home_starts,
        fire && item.command == CMD_HOME && !homing_reg && !at_end, homing_reg,
        "homing request away from the endstop did not start a run")

endmodule

`default_nettype wire

// ===== rtl/stepper_position_homing_controller_top.sv =====
// Top level of the stepper position and homing controller.
//
//  Channel  Direction  Signals                       Contents
//  s_*      in         tvalid tready tdata tuser     one command with endstop level
//  m_*      out        tvalid tready tdata           one result per request
//  cfg_*    in         cfg_we cfg_index cfg_data     register write, no read-back
//
// One request is accepted every cycle while the output is not stalled.
// Requests pass an input register, the combinational axis update and an output register.
// Reset clears the axis state and loads the register defaults.
// A stalled output holds its result, and the input stops only when both registers are full.
`default_nettype none

module stepper_position_homing_controller_top #(
    parameter int STEP_BITS = spc_pkg::STEP_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // [6:0] target_percent, [7] endstop_level
    input  wire logic [7:0]                    s_tdata,
    // [1:0] command
    input  wire logic [spc_pkg::CMD_W-1:0]     s_tuser,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // [0] step_pulse, [1] dir_level, [2] enable_level, [4:3] motion_state,
    // [5] position_valid, [21:6] position, [22] homing_active, [23] zero
    output      logic [23:0]                   m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [spc_pkg::CFG_W-1:0]     cfg_data
);
    import spc_pkg::*;

    cfg_t  cfg;
    item_t in_reg;
    logic  in_valid_reg;
    res_t  core_res;
    res_t  out_reg;
    logic  out_valid_reg;
    logic  advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg.command        <= s_tuser;
            in_reg.target_percent <= s_tdata[PCT_W-1:0];
            in_reg.endstop_level  <= s_tdata[PCT_W];
        end
        if (advance)
        begin
            out_reg <= core_res;
        end
    end

    spc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spc_core #(
        .STEP_BITS (STEP_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (advance),
        .item  (in_reg),
        .res   (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.homing_active, out_reg.position, out_reg.position_valid,
                       out_reg.motion_state, out_reg.enable_level, out_reg.dir_level,
                       out_reg.step_pulse};

endmodule

`default_nettype wire
